/* hw/rtl/mvm_pkg.sv */
// Shared constants and types of the matrix-vector multiplier.
package mvm_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_DIM_DEFAULT    = 16;
    localparam int DATA_WIDTH_DEFAULT = 16;

    // Fixed field widths of the ports.
    localparam int OUT_W      = 32;
    localparam int OUT_IDX_W  = 4;
    localparam int ROW_COL_W  = 4;
    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 2'd2;

    // Reset values of the dimension registers.
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 5'd16;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic acc_clear;
        logic mul_en;
    } mac_ctrl_t;

endpackage

/* hw/rtl/mvm_mac.sv */
// Shared multiply-accumulate unit with a saturating Q16.16 read-out.
module mvm_mac #(
    parameter int VAL_BITS = 16,
    parameter int TERMS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mvm_pkg::mac_ctrl_t            ctrl,
    input  logic signed [VAL_BITS-1:0]    weight,
    input  logic signed [VAL_BITS-1:0]    element,
    output logic                          busy,
    output logic [mvm_pkg::OUT_W-1:0]     sum_value,
    output logic                          sum_clamped
);
    import mvm_pkg::*;

    localparam int PW    = 2 * VAL_BITS;
    localparam int ACC_W = PW + $clog2(TERMS) + 1;
    localparam int WIDE  = 64;

    localparam logic signed [WIDE-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [WIDE-1:0] SAT_LO = -64'sd2147483648;

    logic signed [PW-1:0]    prod_reg;
    logic                    prod_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [WIDE-1:0]  acc_wide;

    // Product register: one multiplication per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= weight * element;
        end
    end

    // Accumulator: cleared at the start of each output element.
    assign prod_ext = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    // Clamp the exact sum into signed 32 bits.
    assign acc_wide = {{(WIDE-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};

    always_comb
    begin
        if (acc_wide > SAT_HI)
        begin
            sum_value   = SAT_HI[OUT_W-1:0];
            sum_clamped = 1'b1;
        end
        else if (acc_wide < SAT_LO)
        begin
            sum_value   = SAT_LO[OUT_W-1:0];
            sum_clamped = 1'b1;
        end
        else
        begin
            sum_value   = acc_wide[OUT_W-1:0];
            sum_clamped = 1'b0;
        end
    end

    assign busy = prod_vld_reg;

endmodule

/* hw/rtl/matrix_vector_multiply.sv */
// Top level of the matrix-vector multiplier: stores, sequencer and output register.
//
// Usage: items arrive on the item channel (item_valid / item_stall). A kind 0
// item writes one Q8.8 weight. A kind 1 item appends one vector element; the
// element marked last starts the product W*v, or W-transposed*v when the
// transpose register is set. Results leave on the result channel
// (result_valid / result_stall), one transaction per output element, the
// final one marked out_last. A wrong vector length gives one transaction
// with length_error set instead of a product.
// One shared multiply-accumulate unit does all products. For each output
// element the sequencer reads the n weight and element pairs (n = vector
// length), drains the memory-read and multiply pipeline, then loads the
// output register with the result.
// item_stall stays high from the last element until the final result is taken.
// Reset: the weight memory is swept to zero, one entry per cycle, over all
// 2^(2*clog2(MAX_DIM)) entries (256 at the default size) with item_stall high;
// configuration writes are taken at any time.
// A stalled result holds in the output register and the sequencer waits.
module matrix_vector_multiply #(
    parameter int MAX_DIM    = mvm_pkg::MAX_DIM_DEFAULT,
    parameter int DATA_WIDTH = mvm_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                write_enable,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]       reg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]      write_data,
    // Item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                kind,
    input  logic [mvm_pkg::ROW_COL_W-1:0]       weight_row,
    input  logic [mvm_pkg::ROW_COL_W-1:0]       weight_col,
    input  logic signed [mvm_pkg::VALUE_W-1:0]  value,
    input  logic                                last,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [mvm_pkg::OUT_IDX_W-1:0]       out_index,
    output logic signed [mvm_pkg::OUT_W-1:0]    out_value,
    output logic                                out_last,
    output logic                                length_error,
    output logic                                saturated
);
    import mvm_pkg::*;

    localparam int VAL_BITS = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int WA_W     = 2 * IDX_W;
    localparam int WDEPTH   = 1 << WA_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } mvm_state_t;

    // Registers
    mvm_state_t             state_reg, state_next;
    logic [WA_W-1:0]        clear_addr_reg, clear_addr_next;
    logic [CFG_DATA_W-1:0]  rows_reg, rows_next;
    logic [CFG_DATA_W-1:0]  cols_reg, cols_next;
    logic                   tr_cfg_reg, tr_cfg_next;
    logic [DIM_W-1:0]       vec_count_reg, vec_count_next;
    logic                   overflow_reg, overflow_next;
    logic [DIM_W-1:0]       n_reg, n_next;
    logic [DIM_W-1:0]       outn_reg, outn_next;
    logic                   tr_reg, tr_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   result_valid_reg, result_valid_next;
    logic [OUT_IDX_W-1:0]   out_index_reg, out_index_next;
    logic [OUT_W-1:0]       out_value_reg, out_value_next;
    logic                   out_last_reg, out_last_next;
    logic                   err_reg, err_next;
    logic                   sat_reg, sat_next;

    // Memories and read registers
    logic signed [VAL_BITS-1:0] wmem [WDEPTH];
    logic signed [VAL_BITS-1:0] vmem [MAX_DIM];
    logic signed [VAL_BITS-1:0] w_q_reg;
    logic signed [VAL_BITS-1:0] v_q_reg;

    // Combinational signals
    logic                       item_take;
    logic signed [VAL_BITS-1:0] value_low;
    logic                       row_ok;
    logic                       col_ok;
    logic [IDX_W-1:0]           row_idx;
    logic [IDX_W-1:0]           col_idx;
    logic [DIM_W-1:0]           rows_dim;
    logic [DIM_W-1:0]           cols_dim;
    logic [DIM_W-1:0]           need_dim;
    logic [DIM_W-1:0]           outn_dim;
    logic                       room;
    logic [DIM_W-1:0]           count_inc;
    logic                       ovf_new;
    logic                       wmem_we;
    logic [WA_W-1:0]            wmem_waddr;
    logic signed [VAL_BITS-1:0] wmem_wdata;
    logic                       vmem_we;
    logic                       rd_en;
    logic [WA_W-1:0]            rd_addr;
    mac_ctrl_t                  mac_ctrl;
    logic                       mac_busy;
    logic [OUT_W-1:0]           sum_value;
    logic                       sum_clamped;

    // Input field decode.
    assign item_take = item_valid && (state_reg == ST_IDLE);
    assign value_low = value[VAL_BITS-1:0];
    assign row_ok    = 32'(weight_row) < MAX_DIM;
    assign col_ok    = 32'(weight_col) < MAX_DIM;
    assign row_idx   = IDX_W'(weight_row);
    assign col_idx   = IDX_W'(weight_col);

    // Dimensions clamped into 1..MAX_DIM.
    always_comb
    begin
        if (rows_reg == '0)
        begin
            rows_dim = DIM_W'(1);
        end
        else if (32'(rows_reg) > MAX_DIM)
        begin
            rows_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            rows_dim = DIM_W'(rows_reg);
        end

        if (cols_reg == '0)
        begin
            cols_dim = DIM_W'(1);
        end
        else if (32'(cols_reg) > MAX_DIM)
        begin
            cols_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            cols_dim = DIM_W'(cols_reg);
        end
    end

    assign need_dim  = tr_cfg_reg ? rows_dim : cols_dim;
    assign outn_dim  = tr_cfg_reg ? cols_dim : rows_dim;
    assign room      = vec_count_reg < DIM_W'(MAX_DIM);
    assign count_inc = room ? (vec_count_reg + DIM_W'(1)) : vec_count_reg;
    assign ovf_new   = overflow_reg | ~room;

    // Weight memory addressing: the sweep after reset or an item write, and the read.
    assign wmem_waddr = (state_reg == ST_CLEAR) ? clear_addr_reg : {row_idx, col_idx};
    assign wmem_wdata = (state_reg == ST_CLEAR) ? '0 : value_low;
    assign rd_addr    = tr_reg ? {j_reg, i_reg} : {i_reg, j_reg};

    // Sequencer and configuration next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        clear_addr_next   = clear_addr_reg;
        rows_next         = rows_reg;
        cols_next         = cols_reg;
        tr_cfg_next       = tr_cfg_reg;
        vec_count_next    = vec_count_reg;
        overflow_next     = overflow_reg;
        n_next            = n_reg;
        outn_next         = outn_reg;
        tr_next           = tr_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        result_valid_next = result_valid_reg;
        out_index_next    = out_index_reg;
        out_value_next    = out_value_reg;
        out_last_next     = out_last_reg;
        err_next          = err_reg;
        sat_next          = sat_reg;
        wmem_we           = 1'b0;
        vmem_we           = 1'b0;
        rd_en             = 1'b0;
        mac_ctrl.acc_clear = 1'b0;
        mac_ctrl.mul_en    = rd_vld_reg;

        if (write_enable)
        begin
            case (reg_index)
                REG_ROWS:      rows_next   = write_data;
                REG_COLS:      cols_next   = write_data;
                REG_TRANSPOSE: tr_cfg_next = write_data[0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wmem_we         = 1'b1;
                clear_addr_next = clear_addr_reg + WA_W'(1);
                if (clear_addr_reg == {WA_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (!kind)
                    begin
                        wmem_we = row_ok && col_ok;
                    end
                    else
                    begin
                        vmem_we        = room;
                        vec_count_next = count_inc;
                        overflow_next  = ovf_new;
                        if (last)
                        begin
                            vec_count_next = '0;
                            overflow_next  = 1'b0;
                            if (ovf_new || (count_inc != need_dim))
                            begin
                                // Length mismatch: a single error transaction.
                                result_valid_next = 1'b1;
                                out_index_next    = '0;
                                out_value_next    = '0;
                                out_last_next     = 1'b1;
                                err_next          = 1'b1;
                                sat_next          = 1'b0;
                                state_next        = ST_EMIT;
                            end
                            else
                            begin
                                n_next             = count_inc;
                                outn_next          = outn_dim;
                                tr_next            = tr_cfg_reg;
                                i_next             = '0;
                                j_next             = '0;
                                mac_ctrl.acc_clear = 1'b1;
                                state_next         = ST_RUN;
                            end
                        end
                    end
                end
            end

            ST_RUN:
            begin
                // One weight and one element read per cycle.
                rd_en = 1'b1;
                if ((DIM_W'(j_reg) + DIM_W'(1)) == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            ST_DRAIN:
            begin
                // Wait for the read and multiply stages to empty.
                if (!rd_vld_reg && !mac_busy)
                begin
                    result_valid_next = 1'b1;
                    out_index_next    = OUT_IDX_W'(i_reg);
                    out_value_next    = sum_value;
                    out_last_next     = (DIM_W'(i_reg) + DIM_W'(1)) == outn_reg;
                    err_next          = 1'b0;
                    sat_next          = sum_clamped;
                    state_next        = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next             = i_reg + IDX_W'(1);
                        j_next             = '0;
                        mac_ctrl.acc_clear = 1'b1;
                        state_next         = ST_RUN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_vld_next = rd_en;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clear_addr_reg   <= '0;
            rows_reg         <= DIM_RESET;
            cols_reg         <= DIM_RESET;
            tr_cfg_reg       <= 1'b0;
            vec_count_reg    <= '0;
            overflow_reg     <= 1'b0;
            n_reg            <= '0;
            outn_reg         <= '0;
            tr_reg           <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            rd_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clear_addr_reg   <= clear_addr_next;
            rows_reg         <= rows_next;
            cols_reg         <= cols_next;
            tr_cfg_reg       <= tr_cfg_next;
            vec_count_reg    <= vec_count_next;
            overflow_reg     <= overflow_next;
            n_reg            <= n_next;
            outn_reg         <= outn_next;
            tr_reg           <= tr_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            rd_vld_reg       <= rd_vld_next;
            result_valid_reg <= result_valid_next;
            out_last_reg     <= out_last_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        err_reg       <= err_next;
        sat_reg       <= sat_next;
    end

    // Weight memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wmem_we)
        begin
            wmem[wmem_waddr] <= wmem_wdata;
        end
        if (rd_en)
        begin
            w_q_reg <= wmem[rd_addr];
        end
    end

    // Vector memory: written at the fill count, read at the column step.
    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vec_count_reg[IDX_W-1:0]] <= value_low;
        end
        if (rd_en)
        begin
            v_q_reg <= vmem[j_reg];
        end
    end

    // Shared multiply-accumulate unit.
    mvm_mac #(
        .VAL_BITS (VAL_BITS),
        .TERMS    (MAX_DIM)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .weight      (w_q_reg),
        .element     (v_q_reg),
        .busy        (mac_busy),
        .sum_value   (sum_value),
        .sum_clamped (sum_clamped)
    );

    // Outputs.
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign out_index    = out_index_reg;
    assign out_value    = out_value_reg;
    assign out_last     = out_last_reg;
    assign length_error = err_reg;
    assign saturated    = sat_reg;

endmodule

/* bench/matrix_vector_multiply_tb.sv */
// Self-checking testbench for the matrix-vector multiplier, with its own product predictor.
module matrix_vector_multiply_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mvm_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEFAULT;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT  = 30;
    localparam longint SAT_MAX  = 64'sd2147483647;
    localparam longint SAT_MIN  = -64'sd2147483648;

    // Item kinds on the input channel.
    typedef enum bit {
        KIND_WEIGHT  = 1'b0,
        KIND_ELEMENT = 1'b1
    } item_kind_t;

    // One expected output element.
    typedef struct {
        logic [OUT_IDX_W-1:0]    index;
        logic signed [OUT_W-1:0] value;
        bit                      is_last;
        bit                      len_err;
        bit                      sat;
    } product_t;

    // Clock, reset and block ports.
    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        write_enable = 1'b0;
    logic [CFG_IDX_W-1:0]        reg_index    = '0;
    logic [CFG_DATA_W-1:0]       write_data   = '0;
    logic                        item_valid   = 1'b0;
    logic                        item_stall;
    logic                        kind         = 1'b0;
    logic [ROW_COL_W-1:0]        weight_row   = '0;
    logic [ROW_COL_W-1:0]        weight_col   = '0;
    logic signed [VALUE_W-1:0]   value        = '0;
    logic                        last         = 1'b0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic [OUT_IDX_W-1:0]        out_index;
    logic signed [OUT_W-1:0]     out_value;
    logic                        out_last;
    logic                        length_error;
    logic                        saturated;

    // Predictor state: weights, the vector being collected and the registers.
    logic signed [VALUE_W-1:0]   weight_mem [MAX_DIM][MAX_DIM];
    logic signed [VALUE_W-1:0]   vec_buf [MAX_DIM];
    int unsigned                 vec_count     = 0;
    bit                          vec_overflow  = 1'b0;
    logic [CFG_DATA_W-1:0]       cfg_rows      = DIM_RESET;
    logic [CFG_DATA_W-1:0]       cfg_cols      = DIM_RESET;
    bit                          cfg_transpose = 1'b0;

    // Output elements still owed by the block, oldest first.
    product_t                    expected_products [$];

    // Traffic shaping and bookkeeping.
    int unsigned                 sender_idle_pct = 0;
    int unsigned                 stall_pct       = 0;
    int unsigned                 hold_request    = 0;
    int unsigned                 hold_left       = 0;
    int unsigned                 mismatch_count  = 0;
    int unsigned                 n_items         = 0;
    int unsigned                 n_checked       = 0;
    int unsigned                 n_vectors       = 0;
    int unsigned                 n_len_err       = 0;
    int unsigned                 n_sat           = 0;

    matrix_vector_multiply u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .weight_row   (weight_row),
        .weight_col   (weight_col),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_index    (out_index),
        .out_value    (out_value),
        .out_last     (out_last),
        .length_error (length_error),
        .saturated    (saturated)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Zero the weight and vector copies; the block zeroes its weights after reset.
    initial
    begin
        foreach (weight_mem[r, c])
            weight_mem[r][c] = '0;
        foreach (vec_buf[i])
            vec_buf[i] = '0;
    end

    // Dimension registers are clamped into 1..MAX_DIM by the block.
    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return 32'(d);
    endfunction

    // Vector length that the current settings accept.
    function automatic int unsigned needed_len();
        return cfg_transpose ? clamp_dim(cfg_rows) : clamp_dim(cfg_cols);
    endfunction

    // Random Q8.8 value with the two extremes weighted up.
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Update the predictor with one accepted transaction and queue its products.
    function automatic void predict_item(input item_kind_t k,
                                         input logic [ROW_COL_W-1:0] r,
                                         input logic [ROW_COL_W-1:0] c,
                                         input logic signed [VALUE_W-1:0] v,
                                         input bit lst);
        int unsigned n_rows;
        int unsigned n_cols;
        int unsigned needed;
        int unsigned n_out;
        int unsigned n_got;
        longint      acc;
        product_t    p;
        if (k == KIND_WEIGHT)
        begin
            weight_mem[r][c] = v;
            return;
        end
        if (vec_count < MAX_DIM)
        begin
            vec_buf[vec_count] = v;
            vec_count++;
        end
        else
            vec_overflow = 1'b1;
        if (!lst)
            return;
        n_rows = clamp_dim(cfg_rows);
        n_cols = clamp_dim(cfg_cols);
        needed = cfg_transpose ? n_rows : n_cols;
        n_out  = cfg_transpose ? n_cols : n_rows;
        n_got  = vec_count;
        vec_count = 0;
        // A wrong or overflowing length gives one error transaction.
        if (vec_overflow || n_got != needed)
        begin
            vec_overflow = 1'b0;
            p.index   = '0;
            p.value   = '0;
            p.is_last = 1'b1;
            p.len_err = 1'b1;
            p.sat     = 1'b0;
            expected_products.push_back(p);
            return;
        end
        // Exact wide sums, clamped to signed 32 bits.
        for (int i = 0; i < n_out; i++)
        begin
            acc = 0;
            for (int j = 0; j < n_got; j++)
            begin
                if (cfg_transpose)
                    acc += longint'(weight_mem[j][i]) * longint'(vec_buf[j]);
                else
                    acc += longint'(weight_mem[i][j]) * longint'(vec_buf[j]);
            end
            p.sat = 1'b0;
            if (acc > SAT_MAX)
            begin
                acc   = SAT_MAX;
                p.sat = 1'b1;
            end
            else if (acc < SAT_MIN)
            begin
                acc   = SAT_MIN;
                p.sat = 1'b1;
            end
            p.index   = OUT_IDX_W'(i);
            p.value   = acc[OUT_W-1:0];
            p.is_last = (i + 1 == n_out);
            p.len_err = 1'b0;
            expected_products.push_back(p);
        end
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one transaction, idling first at the phase's rate, until it is accepted.
    task automatic send_item(input item_kind_t k,
                             input logic [ROW_COL_W-1:0] r,
                             input logic [ROW_COL_W-1:0] c,
                             input logic signed [VALUE_W-1:0] v,
                             input bit lst);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        weight_row <= r;
        weight_col <= c;
        value      <= v;
        last       <= lst;
        do
            @(posedge clk);
        while (item_stall);
        n_items++;
        predict_item(k, r, c, v, lst);
    endtask

    // A burst of weight writes, mostly inside the region in use.
    task automatic send_weights(input int unsigned count);
        logic [ROW_COL_W-1:0] r;
        logic [ROW_COL_W-1:0] c;
        repeat (count)
        begin
            r = ($urandom_range(3) == 0)
                ? ROW_COL_W'($urandom_range(15))
                : ROW_COL_W'($urandom_range(clamp_dim(cfg_rows) - 1));
            c = ($urandom_range(3) == 0)
                ? ROW_COL_W'($urandom_range(15))
                : ROW_COL_W'($urandom_range(clamp_dim(cfg_cols) - 1));
            send_item(KIND_WEIGHT, r, c, rand_value(), 1'($urandom_range(1)));
        end
    endtask

    // A vector of the given length, marked last on its final element.
    task automatic send_vector(input int unsigned len);
        for (int i = 0; i < len; i++)
            send_item(KIND_ELEMENT, ROW_COL_W'($urandom_range(15)),
                      ROW_COL_W'($urandom_range(15)), rand_value(), i == len - 1);
    endtask

    // Wait until every product has come back and the block has settled.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers, one per cycle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] rows,
                              input logic [CFG_DATA_W-1:0] cols,
                              input bit tr);
        write_enable <= 1'b1;
        reg_index    <= REG_ROWS;
        write_data   <= rows;
        @(posedge clk);
        reg_index    <= REG_COLS;
        write_data   <= cols;
        @(posedge clk);
        reg_index    <= REG_TRANSPOSE;
        write_data   <= {{(CFG_DATA_W-1){1'b0}}, tr};
        @(posedge clk);
        write_enable <= 1'b0;
        cfg_rows      = rows;
        cfg_cols      = cols;
        cfg_transpose = tr;
    endtask

    // Receiver: a long hold-off when one is requested, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare every accepted result with the oldest expected product.
    always @(posedge clk)
    begin : check_results
        product_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_products.size() == 0)
                report_mismatch($sformatf("unexpected result, index %0d value %0d",
                                          out_index, out_value));
            else
            begin
                want = expected_products.pop_front();
                n_checked++;
                if (want.is_last)
                    n_vectors++;
                if (want.len_err)
                    n_len_err++;
                if (want.sat)
                    n_sat++;
                if (out_index !== want.index)
                    report_mismatch($sformatf("out_index %0d, expected %0d",
                                              out_index, want.index));
                if (out_value !== want.value)
                    report_mismatch($sformatf("out_value %0d, expected %0d (index %0d)",
                                              out_value, want.value, want.index));
                if (out_last !== want.is_last)
                    report_mismatch($sformatf("out_last %b, expected %b (index %0d)",
                                              out_last, want.is_last, want.index));
                if (length_error !== want.len_err)
                    report_mismatch($sformatf("length_error %b, expected %b",
                                              length_error, want.len_err));
                if (saturated !== want.sat)
                    report_mismatch($sformatf("saturated %b, expected %b (index %0d)",
                                              saturated, want.sat, want.index));
            end
        end
    end

    // Extremes, saturation both ways, a length error, a flagged weight write and transpose.
    task automatic test_directed();
        set_config(5'd2, 5'd3, 1'b0);
        send_item(KIND_WEIGHT, 4'd0, 4'd0, 16'sh8000, 1'b0);
        send_item(KIND_WEIGHT, 4'd0, 4'd1, 16'sh8000, 1'b0);
        send_item(KIND_WEIGHT, 4'd0, 4'd2, 16'sh8000, 1'b0);
        send_item(KIND_WEIGHT, 4'd1, 4'd0, 16'sh7fff, 1'b1);
        send_item(KIND_WEIGHT, 4'd1, 4'd1, -16'sd1, 1'b0);
        send_item(KIND_WEIGHT, 4'd15, 4'd15, 16'sh7fff, 1'b0);
        // Row 0 clamps high, then low.
        send_item(KIND_ELEMENT, 4'd15, 4'd0, 16'sh8000, 1'b0);
        send_item(KIND_ELEMENT, 4'd0, 4'd15, 16'sh8000, 1'b0);
        send_item(KIND_ELEMENT, 4'd7, 4'd9, 16'sh8000, 1'b1);
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh7fff, 1'b0);
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh7fff, 1'b0);
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh7fff, 1'b1);
        // Too short for three columns.
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh0100, 1'b0);
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh0100, 1'b1);
        wait_drained();
        // Transposed: two elements in, three out.
        set_config(5'd2, 5'd3, 1'b1);
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh7fff, 1'b0);
        send_item(KIND_ELEMENT, 4'd0, 4'd0, 16'sh8000, 1'b1);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        set_config(5'd4, 5'd4, 1'b0);
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_request    = 400;
        send_vector(4);
        send_weights(4);
        send_vector(4);
        wait_drained();
    endtask

    // One random phase: settings, traffic shaping, then mixed sequences.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols,
                             input bit tr,
                             input int unsigned idle,
                             input int unsigned stall,
                             input int unsigned quota);
        int unsigned start_count;
        int unsigned pick;
        set_config(rows, cols, tr);
        sender_idle_pct = idle;
        stall_pct       = stall;
        start_count     = n_items;
        while (n_items - start_count < quota)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                send_weights($urandom_range(1, 6));
            else if (pick < 9)
                send_vector(needed_len());
            else if ($urandom_range(2) == 0)
                send_vector($urandom_range(MAX_DIM + 1, MAX_DIM + 4));
            else
                send_vector($urandom_range(1, MAX_DIM));
        end
        wait_drained();
    endtask

    // Random traffic over several settings, clamped values and all idle patterns.
    task automatic test_random();
        run_phase(5'd16, 5'd16, 1'b0, 0,  0,  70);
        run_phase(5'd3,  5'd5,  1'b0, 61, 0,  60);
        run_phase(5'd5,  5'd3,  1'b1, 0,  61, 60);
        run_phase(5'd1,  5'd1,  1'b0, 32, 32, 40);
        run_phase(5'd0,  5'd31, 1'b1, 61, 0,  50);
        run_phase(5'd31, 5'd0,  1'b0, 0,  61, 50);
        run_phase(5'd7,  5'd2,  1'b1, 32, 32, 60);
        run_phase(5'd16, 5'd16, 1'b1, 0,  0,  60);
        run_phase(5'd2,  5'd16, 1'b0, 32, 32, 50);
    endtask

    // Main sequence.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        sender_idle_pct = 0;
        stall_pct       = 0;
        wait_drained();
        repeat (40) @(posedge clk);
        $display("Sent %0d transactions; checked %0d results over %0d vectors.",
                 n_items, n_checked, n_vectors);
        $display("Results with a length error: %0d; clamped sums: %0d.",
                 n_len_err, n_sat);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", expected_products.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
